/* design/dtfd_pkg.sv */
// ----------------------------------------------------------------------------
// dtfd_pkg
// Shared types, register map and helpers for the dual-tap feedback delay.
// ----------------------------------------------------------------------------
`default_nettype none

package dtfd_pkg;

    // sample and word formats
    localparam int SAMPLE_W = 24;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_left;
        logic signed [SAMPLE_W-1:0] sample_right;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
    } t_out_word;

    // default structure
    localparam int DEF_LINE_LENGTH = 65536;
    localparam int DEF_CHANNELS    = 2;
    localparam int TAPS            = 2;

    // control port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    typedef enum logic [2:0] {
        REG_DELAY_A  = 3'd0,
        REG_DELAY_B  = 3'd1,
        REG_FEEDBACK = 3'd2,
        REG_WET_MIX  = 3'd3,
        REG_CHANNELS = 3'd4
    } t_reg_idx;

    // register widths and reset values
    localparam int DELAY_W = 24;
    localparam int GAIN_W  = 16;
    localparam int MIX_W   = 17;
    localparam int CHCNT_W = 2;

    localparam logic [DELAY_W-1:0] RST_DELAY_A  = 24'd3072000;
    localparam logic [DELAY_W-1:0] RST_DELAY_B  = 24'd4608000;
    localparam logic [GAIN_W-1:0]  RST_FEEDBACK = 16'd19661;
    localparam logic [MIX_W-1:0]   RST_WET_MIX  = 17'd22938;
    localparam logic [CHCNT_W-1:0] RST_CHANNELS = 2'd2;

    localparam logic [MIX_W-1:0] MIX_UNITY = 17'd65536;

    // clamp a wide signed value to the 24-bit sample range
    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [47:0] v);
        logic signed [SAMPLE_W-1:0] res;
        if (v > 48'sd8388607) begin
            res = 24'sh7FFFFF;
        end else if (v < -48'sd8388608) begin
            res = 24'sh800000;
        end else begin
            res = v[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* design/dtfd_ram.sv */
// ----------------------------------------------------------------------------
// dtfd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dtfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/dual_tap_feedback_delay.sv */
// Each accepted word is held while the delays are folded (S_RED, skipped
// at the default line length), the read positions are set (S_POS) and each
// of the 0..CHANNELS active channels runs both taps and the wet/dry mix in turn.
// No new word is taken until the last result is loaded for output; the
// single read port of the delay RAM serves two reads per tap and channel.
// Reset: RAM cleared one entry a cycle (4*LINE_LENGTH, 262144) while stalled.
// ----------------------------------------------------------------------------
// dual_tap_feedback_delay
// Stereo two-tap feedback delay with linear interpolation and wet/dry mix.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_tap_feedback_delay #(
    parameter int LINE_LENGTH = dtfd_pkg::DEF_LINE_LENGTH,
    parameter int CHANNELS    = dtfd_pkg::DEF_CHANNELS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input words
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire dtfd_pkg::t_in_word            i_in_word,
    // result words
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output dtfd_pkg::t_out_word                o_out_word,
    // control port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dtfd_pkg::APB_AW-1:0]   paddr,
    input  wire logic [dtfd_pkg::APB_DW-1:0]   pwdata,
    output logic      [dtfd_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);

    // structure
    localparam int LINE_AW = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1;
    localparam int NLINES  = dtfd_pkg::TAPS * CHANNELS;
    localparam int LN_W    = (NLINES > 1) ? $clog2(NLINES) : 1;
    localparam int DEPTH   = NLINES * LINE_LENGTH;
    localparam int AW      = $clog2(DEPTH);
    localparam int TOT     = LINE_LENGTH * 256;
    localparam int P_W     = $clog2(TOT);
    localparam int PX      = P_W + 1;
    // long-division steps to fold a 24-bit delay below one line
    localparam int RED_STEPS = (TOT >= 2**24) ? 0 : 25 - $clog2(TOT + 1);
    localparam int K_W       = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
    localparam logic [24:0] TOT25 = 25'(TOT);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RED, S_POS, S_RD0, S_RD1, S_INT, S_FB, S_WR,
        S_MX1, S_MX2, S_MX3, S_OUT
    } t_state;

    // configuration registers
    logic [dtfd_pkg::DELAY_W-1:0] r_delay_a, r_delay_b;
    logic [dtfd_pkg::GAIN_W-1:0]  r_gain;
    logic [dtfd_pkg::MIX_W-1:0]   r_mix;
    logic [dtfd_pkg::CHCNT_W-1:0] r_chcnt;

    // sequencer state
    t_state                       r_state;
    logic [AW-1:0]                r_clr;
    logic [LINE_AW-1:0]           r_wp;
    logic [K_W-1:0]               r_k;
    logic [dtfd_pkg::DELAY_W-1:0] r_da, r_db;
    logic [LINE_AW-1:0]           r_i0 [dtfd_pkg::TAPS];
    logic [LINE_AW-1:0]           r_i1 [dtfd_pkg::TAPS];
    logic [7:0]                   r_fr [dtfd_pkg::TAPS];
    logic                         r_tap;
    logic                         r_ch;
    logic signed [23:0]           r_x_l, r_x_r;
    logic signed [23:0]           r_y_l, r_y_r;
    logic signed [23:0]           r_s0;
    logic signed [24:0]           r_dl;
    logic signed [41:0]           r_fbp;
    logic signed [25:0]           r_wsum;
    logic signed [41:0]           r_p1;
    logic signed [43:0]           r_p2;
    logic                         r_out_vld;
    dtfd_pkg::t_out_word          r_out;

    // memory port signals
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr, mem_raddr;
    logic [23:0]                  mem_wdata, mem_rdata;

    // datapath helpers
    logic                         cfg_wr;
    logic [dtfd_pkg::CHCNT_W-1:0] nch;
    logic [dtfd_pkg::MIX_W-1:0]   m_eff, m_inv;
    logic [LN_W-1:0]              line;
    logic [AW-1:0]                line_base;
    logic signed [23:0]           x_sel;
    logic [24:0]                  red_sub;
    logic [P_W-1:0]               pos_a, pos_b;
    logic signed [24:0]           diff;
    logic signed [33:0]           fprod, isum;
    logic signed [41:0]           fsum;
    logic signed [26:0]           wval;
    logic signed [45:0]           msum;
    logic                         out_load;
    logic                         more_ch;

    // fractional read position behind the write pointer
    function automatic logic [P_W-1:0] read_pos(input logic [LINE_AW-1:0] wp,
                                               input logic [dtfd_pkg::DELAY_W-1:0] d);
        logic [PX-1:0] p;
        p = PX'({wp, 8'd0}) + PX'(TOT) - PX'(d);
        if (p >= PX'(TOT)) begin
            p = p - PX'(TOT);
        end
        return p[P_W-1:0];
    endfunction

    // next line index with wrap
    function automatic logic [LINE_AW-1:0] next_idx(input logic [LINE_AW-1:0] i);
        return (i == LINE_AW'(LINE_LENGTH - 1)) ? '0 : i + 1'b1;
    endfunction

    // control port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_a <= dtfd_pkg::RST_DELAY_A;
            r_delay_b <= dtfd_pkg::RST_DELAY_B;
            r_gain    <= dtfd_pkg::RST_FEEDBACK;
            r_mix     <= dtfd_pkg::RST_WET_MIX;
            r_chcnt   <= dtfd_pkg::RST_CHANNELS;
        end else if (cfg_wr) begin
            case (dtfd_pkg::t_reg_idx'(paddr[4:2]))
                dtfd_pkg::REG_DELAY_A:  r_delay_a <= pwdata[dtfd_pkg::DELAY_W-1:0];
                dtfd_pkg::REG_DELAY_B:  r_delay_b <= pwdata[dtfd_pkg::DELAY_W-1:0];
                dtfd_pkg::REG_FEEDBACK: r_gain    <= pwdata[dtfd_pkg::GAIN_W-1:0];
                dtfd_pkg::REG_WET_MIX:  r_mix     <= pwdata[dtfd_pkg::MIX_W-1:0];
                dtfd_pkg::REG_CHANNELS: r_chcnt   <= pwdata[dtfd_pkg::CHCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (dtfd_pkg::t_reg_idx'(paddr[4:2]))
            dtfd_pkg::REG_DELAY_A:  prdata = 32'(r_delay_a);
            dtfd_pkg::REG_DELAY_B:  prdata = 32'(r_delay_b);
            dtfd_pkg::REG_FEEDBACK: prdata = 32'(r_gain);
            dtfd_pkg::REG_WET_MIX:  prdata = 32'(r_mix);
            dtfd_pkg::REG_CHANNELS: prdata = 32'(r_chcnt);
            default:                prdata = '0;
        endcase
    end

    // clamped settings
    assign nch   = (r_chcnt > dtfd_pkg::CHCNT_W'(CHANNELS)) ?
                   dtfd_pkg::CHCNT_W'(CHANNELS) : r_chcnt;
    assign m_eff = (r_mix > dtfd_pkg::MIX_UNITY) ? dtfd_pkg::MIX_UNITY : r_mix;
    assign m_inv = dtfd_pkg::MIX_UNITY - m_eff;

    // line selection and sample of the current channel
    assign line      = LN_W'(r_tap) * LN_W'(CHANNELS) + LN_W'(r_ch);
    assign line_base = AW'(line) * AW'(LINE_LENGTH);
    assign x_sel     = r_ch ? r_x_r : r_x_l;

    // delay folding step and read positions
    assign red_sub = TOT25 << r_k;
    assign pos_a   = read_pos(r_wp, r_da);
    assign pos_b   = read_pos(r_wp, r_db);

    // interpolation: s1 arrives on the read port in S_INT
    assign diff  = $signed({mem_rdata[23], mem_rdata}) - $signed({r_s0[23], r_s0});
    assign fprod = $signed({1'b0, r_fr[r_tap]}) * diff;
    assign isum  = $signed({{2{r_s0[23]}}, r_s0, 8'd0}) + fprod + 34'sd128;

    // feedback write value
    assign fsum = r_fbp + 42'sd32768;
    assign wval = 27'(x_sel) + 27'($signed(fsum[41:16]));

    // wet/dry sum
    assign msum = (46'(r_p1) <<< 1) + 46'(r_p2) + 46'sd65536;

    assign out_load = (r_state == S_OUT) && (!r_out_vld || !i_out_stall);
    assign more_ch  = (dtfd_pkg::CHCNT_W'(r_ch) + 1'b1) < nch;

    // memory port drive
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = line_base + AW'(r_wp);
        mem_wdata = wval[23:0];
        mem_raddr = line_base + AW'(r_i0[r_tap]);
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            S_RD1: begin
                mem_raddr = line_base + AW'(r_i1[r_tap]);
            end
            S_WR: begin
                mem_we    = 1'b1;
                mem_wdata = dtfd_pkg::sat24(48'(wval));
            end
            default: ;
        endcase
    end

    dtfd_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_wp      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && !i_out_stall && !out_load) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x_l <= i_in_word.sample_left;
                        r_x_r <= i_in_word.sample_right;
                        r_y_l <= i_in_word.sample_left;
                        r_y_r <= i_in_word.sample_right;
                        r_da  <= r_delay_a;
                        r_db  <= r_delay_b;
                        r_k   <= K_W'(RED_STEPS - 1);
                        r_state <= (RED_STEPS > 0) ? S_RED : S_POS;
                    end
                end
                S_RED: begin
                    if ({1'b0, r_da} >= red_sub) begin
                        r_da <= r_da - red_sub[23:0];
                    end
                    if ({1'b0, r_db} >= red_sub) begin
                        r_db <= r_db - red_sub[23:0];
                    end
                    if (r_k == '0) begin
                        r_state <= S_POS;
                    end else begin
                        r_k <= r_k - 1'b1;
                    end
                end
                S_POS: begin
                    r_i0[0] <= pos_a[P_W-1:8];
                    r_i1[0] <= next_idx(pos_a[P_W-1:8]);
                    r_fr[0] <= pos_a[7:0];
                    r_i0[1] <= pos_b[P_W-1:8];
                    r_i1[1] <= next_idx(pos_b[P_W-1:8]);
                    r_fr[1] <= pos_b[7:0];
                    r_ch    <= 1'b0;
                    r_tap   <= 1'b0;
                    r_wsum  <= '0;
                    r_state <= (nch == '0) ? S_OUT : S_RD0;
                end
                S_RD0: begin
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_s0    <= mem_rdata;
                    r_state <= S_INT;
                end
                S_INT: begin
                    r_dl    <= isum[32:8];
                    r_state <= S_FB;
                end
                S_FB: begin
                    r_fbp   <= $signed({1'b0, r_gain}) * r_dl;
                    r_wsum  <= r_wsum + 26'(r_dl);
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_tap) begin
                        r_state <= S_MX1;
                    end else begin
                        r_tap   <= 1'b1;
                        r_state <= S_RD0;
                    end
                end
                S_MX1: begin
                    r_p1    <= $signed({1'b0, m_inv}) * x_sel;
                    r_state <= S_MX2;
                end
                S_MX2: begin
                    r_p2    <= $signed({1'b0, m_eff}) * r_wsum;
                    r_state <= S_MX3;
                end
                S_MX3: begin
                    if (r_ch) begin
                        r_y_r <= dtfd_pkg::sat24(48'(msum >>> 17));
                    end else begin
                        r_y_l <= dtfd_pkg::sat24(48'(msum >>> 17));
                    end
                    if (more_ch) begin
                        r_ch    <= 1'b1;
                        r_tap   <= 1'b0;
                        r_wsum  <= '0;
                        r_state <= S_RD0;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out.out_left  <= r_y_l;
                        r_out.out_right <= r_y_r;
                        r_out_vld       <= 1'b1;
                        r_wp            <= next_idx(r_wp);
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // checks
    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= LINE_AW'(LINE_LENGTH - 1))
        else $error("write pointer past line end");

    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> o_in_stall)
        else $error("input taken during clearing pass");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out_valid)
        else $error("loaded result not presented");

    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD0 || r_state == S_RD1 || r_state == S_INT) |-> !mem_we)
        else $error("delay RAM written during a tap read");

    a_channel_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD0) |-> (dtfd_pkg::CHCNT_W'(r_ch) < nch))
        else $error("inactive channel processed");

endmodule

`default_nettype wire

/* sim/tb_dual_tap_feedback_delay.sv */
// ----------------------------------------------------------------------------
// tb_dual_tap_feedback_delay
// Self-checking bench for the dual-tap feedback delay. A scoreboard class
// keeps its own copy of the delay lines, the write pointer and the registers.
// It predicts each result word from the accepted input words. Directed and
// random phases run under random stalls on both sides (none in the quiet
// tail); the registers are reprogrammed over the control port between them.
// ----------------------------------------------------------------------------
module tb_dual_tap_feedback_delay;
    timeunit 1ns;
    timeprecision 1ps;

    import dtfd_pkg::*;

    // bench constants
    localparam int STORE_DEPTH    = TAPS * DEF_CHANNELS * DEF_LINE_LENGTH;
    localparam int REG_UNMAPPED   = 5;
    localparam int RANDOM_WORDS   = 1080;
    localparam int QUIET_TAIL     = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 64;
    localparam int WATCHDOG_LIMIT = 1000000;
    localparam int MAX_REPORTS    = 10;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    // clamp to the signed 24-bit sample range
    function automatic logic signed [SAMPLE_W-1:0] clamp_sample(input longint v);
        if (v > 64'sd8388607) begin
            return SAMPLE_MAX;
        end else if (v < -64'sd8388608) begin
            return SAMPLE_MIN;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    // predicts result words and checks them in order
    class delay_scoreboard;
        bit signed [SAMPLE_W-1:0] line_mem [STORE_DEPTH];
        logic [15:0]              wr_ptr;
        logic [DELAY_W-1:0]       delay_a;
        logic [DELAY_W-1:0]       delay_b;
        logic [GAIN_W-1:0]        fb_gain;
        logic [MIX_W-1:0]         wet;
        logic [CHCNT_W-1:0]       ch_cnt;
        t_out_word                mixed_q [$];
        int                       errors;

        function new();
            wr_ptr  = '0;
            delay_a = RST_DELAY_A;
            delay_b = RST_DELAY_B;
            fb_gain = RST_FEEDBACK;
            wet     = RST_WET_MIX;
            ch_cnt  = RST_CHANNELS;
            errors  = 0;
        endfunction

        // mirror of a register write, unmapped indexes are dropped
        function void write_reg(input int idx, input logic [31:0] value);
            case (idx)
                REG_DELAY_A:  delay_a = value[DELAY_W-1:0];
                REG_DELAY_B:  delay_b = value[DELAY_W-1:0];
                REG_FEEDBACK: fb_gain = value[GAIN_W-1:0];
                REG_WET_MIX:  wet     = value[MIX_W-1:0];
                REG_CHANNELS: ch_cnt  = value[CHCNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return mixed_q.size();
        endfunction

        // run one frame through both taps and queue the mixed word
        function void note_input(input t_in_word w);
            logic [DELAY_W-1:0] dly;
            logic [DELAY_W-1:0] pos;
            logic [15:0]        i0 [TAPS];
            logic [15:0]        i1 [TAPS];
            logic [7:0]         fr [TAPS];
            longint             x [2];
            longint             s0, s1, dl, fbv, wsum, m;
            int                 nch, t, ch, base;
            t_out_word          res;

            nch = (ch_cnt > DEF_CHANNELS) ? DEF_CHANNELS : int'(ch_cnt);
            m   = (wet > MIX_UNITY) ? 64'sd65536 : longint'(wet);

            // fractional read position behind the write pointer
            for (t = 0; t < TAPS; t++) begin
                dly   = (t == 0) ? delay_a : delay_b;
                pos   = {wr_ptr, 8'h00} - dly;
                i0[t] = pos[23:8];
                fr[t] = pos[7:0];
                i1[t] = i0[t] + 16'd1;
            end

            x[0] = longint'(w.sample_left);
            x[1] = longint'(w.sample_right);
            res.out_left  = w.sample_left;
            res.out_right = w.sample_right;

            // interpolate, feed back and mix per active channel
            for (ch = 0; ch < nch; ch++) begin
                wsum = 0;
                for (t = 0; t < TAPS; t++) begin
                    base = (t * DEF_CHANNELS + ch) * DEF_LINE_LENGTH;
                    s0   = longint'(line_mem[base + int'(i0[t])]);
                    s1   = longint'(line_mem[base + int'(i1[t])]);
                    dl   = (s0 * 256 + longint'(fr[t]) * (s1 - s0) + 128) >>> 8;
                    fbv  = (longint'(fb_gain) * dl + 32768) >>> 16;
                    line_mem[base + int'(wr_ptr)] = clamp_sample(x[ch] + fbv);
                    wsum += dl;
                end
                if (ch == 0) begin
                    res.out_left = clamp_sample((2 * x[0] * (65536 - m) + wsum * m + 65536) >>> 17);
                end else begin
                    res.out_right = clamp_sample((2 * x[1] * (65536 - m) + wsum * m + 65536) >>> 17);
                end
            end

            wr_ptr = wr_ptr + 16'd1;
            mixed_q.push_back(res);
        endfunction

        // compare one result word with the oldest prediction
        function void check_result(input t_out_word got);
            t_out_word exp_w;
            if (mixed_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("[%0t] unexpected result word: left %0d right %0d",
                             $realtime, got.out_left, got.out_right);
                end
                return;
            end
            exp_w = mixed_q.pop_front();
            if (got.out_left !== exp_w.out_left || got.out_right !== exp_w.out_right) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("[%0t] result mismatch: left exp %0d got %0d, right exp %0d got %0d",
                             $realtime, exp_w.out_left, got.out_left,
                             exp_w.out_right, got.out_right);
                end
            end
        endfunction
    endclass

    // block signals
    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in_word            i_in_word;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out_word           o_out_word;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    delay_scoreboard     sb;
    bit                  quiet_mode;
    bit                  hold_request;
    int                  idle_cycles;

    dual_tap_feedback_delay dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // handshake monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && i_in_valid && o_in_stall === 1'b0) begin
            sb.note_input(i_in_word);
            idle_cycles = 0;
        end else if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && !i_out_stall) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && !i_out_stall) begin
            sb.check_result(o_out_word);
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side stall: random bursts, long hold on request
    initial begin : result_side
        int  run_len;
        bit  stalled;
        run_len = 0;
        stalled = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_request = 1'b0;
                run_len = 0;
            end else if (quiet_mode) begin
                i_out_stall <= 1'b0;
            end else begin
                if (run_len == 0) begin
                    stalled = ($urandom_range(0, 2) == 0);
                    run_len = $urandom_range(1, 19);
                end
                i_out_stall <= stalled;
                run_len--;
            end
        end
    end

    // one register write over the control port, then the bus is left idle
    task automatic reg_write(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx[2:0], 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [31:0] dly_a, input logic [31:0] dly_b,
                                input logic [31:0] gain, input logic [31:0] mix,
                                input logic [31:0] chans);
        reg_write(REG_DELAY_A, dly_a);
        reg_write(REG_DELAY_B, dly_b);
        reg_write(REG_FEEDBACK, gain);
        reg_write(REG_WET_MIX, mix);
        reg_write(REG_CHANNELS, chans);
    endtask

    // offer one input word, at times with a random gap before it outside quiet mode
    task automatic offer_frame(input logic signed [SAMPLE_W-1:0] left,
                               input logic signed [SAMPLE_W-1:0] right);
        t_in_word w;
        w.sample_left  = left;
        w.sample_right = right;
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    // stop offering and wait for every predicted word
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return r[31] ? -$signed(24'($urandom_range(0, 2000)))
                            : $signed(24'($urandom_range(0, 2000)));
            default: return r[SAMPLE_W-1:0];
        endcase
    endfunction

    function automatic logic [31:0] pick_delay();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 24'hFFFFFF);
            1: return $urandom_range(0, 255);
            default: return $urandom_range(256, 200 * 256);
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 62259;
            2: return $urandom_range(62260, 65535);
            default: return $urandom_range(0, 62259);
        endcase
    endfunction

    function automatic logic [31:0] pick_mix();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 65536;
            2: return $urandom_range(65537, 131071);
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    function automatic logic [31:0] pick_channels();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return 3;
            default: return 2;
        endcase
    endfunction

    // test sequence
    initial begin : main_flow
        int sent;
        int phase;
        int n;
        int k;

        sb = new();
        quiet_mode   = 1'b0;
        hold_request = 1'b0;
        idle_cycles  = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // half-sample and one-sample taps, feedback above 0.95, fully wet
        program_regs(128, 256, 65535, 65536, 2);
        offer_frame(SAMPLE_MAX, SAMPLE_MIN);
        offer_frame(SAMPLE_MAX, SAMPLE_MIN);
        offer_frame(SAMPLE_MAX, SAMPLE_MAX);
        offer_frame(SAMPLE_MIN, SAMPLE_MIN);
        offer_frame(24'sd0, 24'sd0);
        offer_frame(-24'sd1, 24'sd1);
        offer_frame(24'sd1, -24'sd1);
        offer_frame(SAMPLE_MAX, SAMPLE_MIN);
        drain_results();

        // zero delay and maximum delay, no feedback, mix above unity, too many channels
        program_regs(0, 24'hFFFFFF, 0, 131071, 3);
        offer_frame(SAMPLE_MIN, SAMPLE_MAX);
        offer_frame(SAMPLE_MAX, SAMPLE_MIN);
        offer_frame(24'sh123456, -24'sh654321);
        offer_frame(pick_sample(), pick_sample());
        offer_frame(pick_sample(), pick_sample());
        drain_results();

        // left channel only, fully dry
        program_regs(3 * 256 + 77, 5 * 256, 62259, 0, 1);
        offer_frame(SAMPLE_MAX, SAMPLE_MIN);
        offer_frame(SAMPLE_MIN, SAMPLE_MAX);
        offer_frame(pick_sample(), pick_sample());
        offer_frame(pick_sample(), pick_sample());
        drain_results();

        // no channel processed, plus a write to an unmapped register
        program_regs(2 * 256, 7 * 256 + 200, 40000, 32768, 0);
        reg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        offer_frame(SAMPLE_MAX, SAMPLE_MIN);
        offer_frame(SAMPLE_MIN, SAMPLE_MAX);
        offer_frame(pick_sample(), pick_sample());
        offer_frame(pick_sample(), pick_sample());
        drain_results();

        // random phases with random settings
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            n = $urandom_range(40, 140);
            if (n > RANDOM_WORDS - sent) begin
                n = RANDOM_WORDS - sent;
            end
            if (RANDOM_WORDS - sent <= QUIET_TAIL) begin
                quiet_mode = 1'b1;
            end
            program_regs(pick_delay(), pick_delay(), pick_gain(), pick_mix(), pick_channels());
            if (phase == 2) begin
                hold_request = 1'b1;
            end
            for (k = 0; k < n; k++) begin
                offer_frame(pick_sample(), pick_sample());
            end
            sent += n;
            phase++;
            drain_results();
        end

        repeat (END_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
